// ===== rtl/aes_pkg.sv =====
// AES-128 package: S-box functions, GF(2^8) helpers and round transforms.
// Used by aes_keyexp, aes_round and the top level aes128_block_cipher.
package aes_pkg;

	localparam int unsigned RoundCount = 10;

	// Key register byte addresses on the configuration port.
	localparam logic [3:0] AddrKeyHigh = 4'd0;
	localparam logic [3:0] AddrKeyLow = 4'd8;

	typedef enum logic [0:0] {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_LOAD,
		CS_ROUND,
		CS_DONE
	} core_state_t;

	typedef enum logic [1:0] {
		KS_IDLE,
		KS_SEED,
		KS_RUN
	} key_state_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h00;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				r = r ^ p;
			end
			p = xtime(p);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h01;
		p = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) begin
				r = gmul(r, p);
			end
			p = gmul(p, p);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		rotl8 = (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] a);
		logic [7:0] v;
		v = ginv(a);
		sbox_calc = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
		inv_sbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sbox_tab_t [256];

	function automatic sbox_tab_t make_sbox(input logic inv);
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
		end
		make_sbox = t;
	endfunction

	localparam sbox_tab_t SBOX = make_sbox(1'b0);
	localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// State byte i lies at bits 127-8i .. 120-8i; column c is bytes 4c..4c+3.
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		int src;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				src = inv ? 4 * ((c - k + 4) % 4) + k : 4 * ((c + k) % 4) + k;
				t[127 - 8 * (4 * c + k) -: 8] = inv ? INV_SBOX[s[127 - 8 * src -: 8]]
					: SBOX[s[127 - 8 * src -: 8]];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] a [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = s[127 - 8 * (4 * c + k) -: 8];
			end
			for (int k = 0; k < 4; k++) begin
				t[127 - 8 * (4 * c + k) -: 8] = inv
					? gmul(8'h0e, a[k]) ^ gmul(8'h0b, a[(k + 1) % 4])
						^ gmul(8'h0d, a[(k + 2) % 4]) ^ gmul(8'h09, a[(k + 3) % 4])
					: xtime(a[k]) ^ xtime(a[(k + 1) % 4]) ^ a[(k + 1) % 4]
						^ a[(k + 2) % 4] ^ a[(k + 3) % 4];
			end
		end
		mix_cols = t;
	endfunction

endpackage

// ===== rtl/aes_keyexp.sv =====
// AES-128 key expansion sequencer and round-key memory (4 words per row, 11 rows).
// Depends on aes_pkg.
module aes_keyexp (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [3:0]   rd_row,
	output logic [127:0] rd_key,
	output logic         busy
);

	localparam logic [3:0] LastRow = 4'(aes_pkg::RoundCount - 1);

	aes_pkg::key_state_t state_q, state_nx;
	logic [127:0] mem [aes_pkg::RoundCount + 1];
	logic [127:0] prev_q;
	logic [3:0]   row_q;
	logic [7:0]   rcon_q;
	logic [127:0] next_key;
	logic [31:0]  t;

	always_comb begin
		t = aes_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
		next_key[127:96] = prev_q[127:96] ^ t;
		next_key[95:64]  = prev_q[95:64] ^ next_key[127:96];
		next_key[63:32]  = prev_q[63:32] ^ next_key[95:64];
		next_key[31:0]   = prev_q[31:0] ^ next_key[63:32];
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aes_pkg::KS_IDLE: if (start) state_nx = aes_pkg::KS_SEED;
			aes_pkg::KS_SEED: if (!start) state_nx = aes_pkg::KS_RUN;
			aes_pkg::KS_RUN: begin
				if (start) state_nx = aes_pkg::KS_SEED;
				else if (row_q == LastRow) state_nx = aes_pkg::KS_IDLE;
			end
			default: state_nx = aes_pkg::KS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::KS_SEED;
			row_q   <= 4'd0;
			rcon_q  <= 8'h01;
		end else begin
			state_q <= state_nx;
			if (start || state_q == aes_pkg::KS_SEED) begin
				row_q  <= 4'd0;
				rcon_q <= 8'h01;
			end else if (state_q == aes_pkg::KS_RUN) begin
				row_q  <= row_q + 4'd1;
				rcon_q <= aes_pkg::xtime(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aes_pkg::KS_SEED) begin
			mem[0] <= key;
			prev_q <= key;
		end else if (state_q == aes_pkg::KS_RUN && !start) begin
			mem[row_q + 4'd1] <= next_key;
			prev_q <= next_key;
		end
		rd_key <= mem[rd_row];
	end

	assign busy = (state_q != aes_pkg::KS_IDLE) || start;

endmodule

// ===== rtl/aes_round.sv =====
// One AES round datapath, shared for encryption and decryption.
// Depends on aes_pkg.
module aes_round (
	input  logic [127:0] st,
	input  logic [127:0] rk,
	input  logic         dec,
	input  logic         first,
	input  logic         last,
	output logic [127:0] nx
);

	logic [127:0] ss;
	logic [127:0] enc_v;
	logic [127:0] dec_v;

	always_comb begin
		ss    = aes_pkg::sub_shift(st, dec);
		enc_v = (last ? ss : aes_pkg::mix_cols(ss, 1'b0)) ^ rk;
		dec_v = last ? (ss ^ rk) : aes_pkg::mix_cols(ss ^ rk, 1'b1);
		if (first) nx = st ^ rk;
		else if (dec) nx = dec_v;
		else nx = enc_v;
	end

endmodule

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 single-block cipher, top level with APB key port and stream channels.
// Depends on aes_pkg, aes_keyexp and aes_round.
//
// The block encrypts (tuser 0) or decrypts (tuser 1) one 128-bit block per
// transaction under the key held in key_high (address 0) and key_low (address 8).
// The eleven round keys live in a synchronous memory, one 128-bit row per round;
// a key write starts an expansion, and an expansion of the zero key runs right
// after reset, during which no block is accepted. After acceptance, a load state
// addresses the first round key; then come the initial key addition and ten
// rounds, one per cycle, each reading its key row from the memory, addressed in
// the cycle before. The result sits in an output register, and the next block
// is accepted only once that register is taken, so the block never holds more
// than one block at a time.
module aes128_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // block_high [63:0], block_low [127:64]
	input  logic         s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // result_high [63:0], result_low [127:64]
);

	localparam logic [3:0] LastRound = 4'(aes_pkg::RoundCount);

	aes_pkg::core_state_t state_q, state_nx;
	logic [63:0]  key_high_q, key_low_q;
	logic [127:0] blk_q, nx;
	logic [127:0] rd_key;
	logic [3:0]   round_q, rd_row;
	logic         dec_q, kbusy, wr, in_acc;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign prdata = paddr[3] ? key_low_q : key_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= 64'h0;
			key_low_q  <= 64'h0;
		end else if (wr) begin
			if (paddr == aes_pkg::AddrKeyHigh) key_high_q <= pwdata;
			else if (paddr == aes_pkg::AddrKeyLow) key_low_q <= pwdata;
		end
	end

	// The expansion seeds from the key registers in the cycle after the write.
	aes_keyexp u_kx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wr && (paddr == aes_pkg::AddrKeyHigh || paddr == aes_pkg::AddrKeyLow)),
		.key    ({key_high_q, key_low_q}),
		.rd_row (rd_row),
		.rd_key (rd_key),
		.busy   (kbusy)
	);

	// Key row order: forward for encryption, backward for decryption.
	always_comb begin
		logic [3:0] r;
		r = (state_q == aes_pkg::CS_LOAD) ? 4'd0 : round_q + 4'd1;
		rd_row = dec_q ? LastRound - r : r;
	end

	aes_round u_rnd (
		.st    (blk_q),
		.rk    (rd_key),
		.dec   (dec_q),
		.first (round_q == 4'd0),
		.last  (round_q == LastRound),
		.nx    (nx)
	);

	assign s_tready = (state_q == aes_pkg::CS_IDLE) && !kbusy;
	assign in_acc = s_tvalid && s_tready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aes_pkg::CS_IDLE:  if (in_acc) state_nx = aes_pkg::CS_LOAD;
			aes_pkg::CS_LOAD:  state_nx = aes_pkg::CS_ROUND;
			aes_pkg::CS_ROUND: if (round_q == LastRound) state_nx = aes_pkg::CS_DONE;
			aes_pkg::CS_DONE:  if (m_tready) state_nx = aes_pkg::CS_IDLE;
			default:           state_nx = aes_pkg::CS_IDLE;
		endcase
	end

	// The state keeps byte 0 in its top bits; the stream carries the high half low.
	always_comb begin
		m_tvalid = (state_q == aes_pkg::CS_DONE);
		m_tdata  = {blk_q[63:0], blk_q[127:64]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::CS_IDLE;
			round_q <= 4'd0;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				dec_q   <= s_tuser;
				round_q <= 4'd0;
			end else if (state_q == aes_pkg::CS_ROUND) begin
				round_q <= (round_q == LastRound) ? 4'd0 : round_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) blk_q <= {s_tdata[63:0], s_tdata[127:64]};
		else if (state_q == aes_pkg::CS_ROUND) blk_q <= nx;
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= LastRound) else $error("round counter overran");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kbusy |-> !s_tready) else $error("accepted during key expansion");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aes_pkg::CS_ROUND && round_q == LastRound) |=> m_tvalid)
		else $error("result missing after final round");

endmodule

// ===== tb/aes128_block_cipher_checker.sv =====
// Checker for the AES-128 block cipher: watches the key port and both stream
// channels, predicts each result with its own cipher model, and counts mismatches.
// Depends on aes_pkg for the opcode type and the key register addresses.
`timescale 1ns / 1ps

module aes128_block_cipher_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           fail_count,
	output int           pending_blocks,
	output int           blocks_checked
);

	logic [63:0] key_hi_q, key_lo_q;
	logic [31:0] sched [44];
	logic [127:0] expected_blocks [$];

	function automatic logic [7:0] mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = mul2(a);
		end
		return r;
	endfunction

	function automatic logic [7:0] gf_inverse(input logic [7:0] a);
		logic [7:0] r;
		r = 8'h01;
		// a^254 by repeated multiplication
		for (int i = 0; i < 254; i++) r = gf_mul(r, a);
		return r;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	logic [7:0] fwd_sub [256];
	logic [7:0] rev_sub [256];

	initial begin
		logic [7:0] v;
		for (int i = 0; i < 256; i++) begin
			v = gf_inverse(8'(i));
			fwd_sub[i] = v ^ rol8(v, 1) ^ rol8(v, 2) ^ rol8(v, 3) ^ rol8(v, 4) ^ 8'h63;
		end
		for (int i = 0; i < 256; i++) rev_sub[fwd_sub[i]] = 8'(i);
	end

	function automatic void build_schedule();
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		sched[0] = key_hi_q[63:32];
		sched[1] = key_hi_q[31:0];
		sched[2] = key_lo_q[63:32];
		sched[3] = key_lo_q[31:0];
		for (int i = 4; i < 44; i++) begin
			t = sched[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
				t ^= {rc, 24'h0};
				rc = mul2(rc);
			end
			sched[i] = sched[i-4] ^ t;
		end
	endfunction

	function automatic logic [127:0] cipher_block(input aes_pkg::op_t op,
		input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a [4];
		logic dec;
		int r;
		dec = (op == aes_pkg::OP_DEC);
		for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
		for (int step = 0; step <= 10; step++) begin
			r = dec ? 10 - step : step;
			if (step != 0) begin
				// Substitution and row shift commute, so one order serves both ways.
				for (int c = 0; c < 4; c++)
					for (int k = 0; k < 4; k++)
						t[4*c+k] = dec ? rev_sub[s[4*((c-k+4)%4)+k]]
							: fwd_sub[s[4*((c+k)%4)+k]];
				s = t;
				if (!dec && step != 10) begin
					for (int c = 0; c < 4; c++) begin
						for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
						for (int k = 0; k < 4; k++)
							s[4*c+k] = gf_mul(8'h02, a[k]) ^ gf_mul(8'h03, a[(k+1)%4])
								^ a[(k+2)%4] ^ a[(k+3)%4];
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 4; k++)
					s[4*c+k] ^= sched[4*r+c][31-8*k -: 8];
			// Decryption mixes after the key addition, except for the last round.
			if (dec && step != 0 && step != 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
					for (int k = 0; k < 4; k++)
						s[4*c+k] = gf_mul(8'h0e, a[k]) ^ gf_mul(8'h0b, a[(k+1)%4])
							^ gf_mul(8'h0d, a[(k+2)%4]) ^ gf_mul(8'h09, a[(k+3)%4]);
				end
			end
		end
		for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
		return blk;
	endfunction

	// The stream carries the high half in the low tdata bits; the model keeps it on top.
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			blocks_checked <= 0;
			expected_blocks.delete();
			key_hi_q = '0;
			key_lo_q = '0;
			build_schedule();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == aes_pkg::AddrKeyHigh) key_hi_q = pwdata;
				else if (paddr == aes_pkg::AddrKeyLow) key_lo_q = pwdata;
				build_schedule();
			end
			if (s_tvalid && s_tready)
				expected_blocks.push_back(cipher_block(aes_pkg::op_t'(s_tuser),
					{s_tdata[63:0], s_tdata[127:64]}));
			if (m_tvalid && m_tready) begin
				if (expected_blocks.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_blocks.pop_front();
					if (m_tdata[63:0] !== want[127:64] || m_tdata[127:64] !== want[63:0]) begin
						if (fail_count < 10)
							$display("result mismatch: high exp %h got %h, low exp %h got %h",
								want[127:64], m_tdata[63:0], want[63:0], m_tdata[127:64]);
						fail_count <= fail_count + 1;
					end
					blocks_checked <= blocks_checked + 1;
				end
			end
		end
	end

	assign pending_blocks = expected_blocks.size();

endmodule

// ===== tb/aes128_block_cipher_tb.sv =====
// Testbench top for the AES-128 block cipher: clock, reset, key writes over APB
// and block stimulus with random idling. Depends on aes_pkg, the block and the checker.
`timescale 1ns / 1ps

module aes128_block_cipher_tb;

	// A phase covers exactly this many blocks; the last phase runs without idling.
	localparam int PHASE_BLOCKS = 150;
	localparam int PHASE_COUNT = 6;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid, s_tready;
	logic [127:0] s_tdata;  // block_high [63:0], block_low [127:64]
	logic         s_tuser;  // opcode
	logic         m_tvalid, m_tready;
	logic [127:0] m_tdata;  // result_high [63:0], result_low [127:64]
	int           fail_count, pending_blocks, blocks_checked;
	bit           allow_idle;

	aes128_block_cipher dut (.*);

	aes128_block_cipher_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls in bursts while idling is allowed, else it always takes.
	initial begin
		int burst;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (allow_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// A key register write: setup cycle, then access cycle.
	task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One block transaction, with a random gap before it when idling is allowed.
	// The block is given with byte 0 on top; the high half goes to the low tdata bits.
	task automatic send_block(input aes_pkg::op_t op, input logic [127:0] blk);
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {blk[63:0], blk[127:64]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Waits for every result to come, then lets a key expansion's worth of time go by.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_blocks != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [127:0] blk;
		logic [63:0] kh, kl;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		allow_idle = 1'b1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the zero reset key, before any register write.
		send_block(aes_pkg::OP_ENC, '0);
		send_block(aes_pkg::OP_DEC, '0);
		send_block(aes_pkg::OP_ENC, '1);
		send_block(aes_pkg::OP_DEC, '1);
		drain();
		// Standard test key, with its known plaintext both ways.
		write_key(aes_pkg::AddrKeyHigh, 64'h2b7e151628aed2a6);
		write_key(aes_pkg::AddrKeyLow, 64'habf7158809cf4f3c);
		repeat (30) @(posedge clk);
		send_block(aes_pkg::OP_ENC, 128'h3243f6a8885a308d313198a2e0370734);
		send_block(aes_pkg::OP_DEC, 128'h3925841d02dc09fbdc118597196a0b32);
		send_block(aes_pkg::OP_ENC, {64'h0, 64'hffffffffffffffff});
		send_block(aes_pkg::OP_DEC, {64'hffffffffffffffff, 64'h0});
		for (int b = 0; b < 128; b += 16) send_block(aes_pkg::op_t'(b[4]), 128'h1 << b);
		drain();
		// Extreme keys, and a partial update that changes only the high half.
		write_key(aes_pkg::AddrKeyHigh, '1);
		write_key(aes_pkg::AddrKeyLow, '1);
		repeat (30) @(posedge clk);
		send_block(aes_pkg::OP_ENC, '0);
		send_block(aes_pkg::OP_DEC, '1);
		drain();
		write_key(aes_pkg::AddrKeyHigh, '0);
		repeat (30) @(posedge clk);
		send_block(aes_pkg::OP_ENC, 128'h00112233445566778899aabbccddeeff);
		send_block(aes_pkg::OP_DEC, 128'h00112233445566778899aabbccddeeff);
		drain();

		// Random phases with a fresh low key half, at random also a fresh high half;
		// the sender stops for results between phases; the last runs without idling.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			kh = rand64();
			kl = rand64();
			if ($urandom_range(0, 1)) write_key(aes_pkg::AddrKeyHigh, kh);
			write_key(aes_pkg::AddrKeyLow, kl);
			repeat (30) @(posedge clk);
			if (p == PHASE_COUNT - 1) allow_idle = 1'b0;
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				blk = {rand64(), rand64()};
				send_block(aes_pkg::op_t'($urandom_range(0, 1)), blk);
			end
			drain();
		end

		$display("covered %0d blocks, encrypt and decrypt, under zero, all-ones,", blocks_checked);
		$display("a standard test key, a partially updated key and random keys");
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
